// ===== src/chacha_pkg.sv =====
`timescale 1ns / 1ps
package chacha_pkg;
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	// register indexes
	localparam logic [2:0] REG_KEY_0 = 3'd0;
	localparam logic [2:0] REG_KEY_1 = 3'd1;
	localparam logic [2:0] REG_KEY_2 = 3'd2;
	localparam logic [2:0] REG_KEY_3 = 3'd3;
	localparam logic [2:0] REG_NONCE_LOW = 3'd4;
	localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [2:0] REG_START_COUNTER = 3'd6;

	// item passed from front to back through the queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       new_block;
		logic       restart;
		logic [5:0] pos;
	} chacha_item_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction
endpackage

// ===== src/chacha_front.sv =====
`timescale 1ns / 1ps
module chacha_front
	import chacha_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output logic         q_valid,
	input  logic         q_ready,
	output chacha_item_t q_item
);
	// two-entry queue towards the back
	chacha_item_t buf_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         started_q;
	logic [5:0]   pos_q;
	chacha_item_t item;
	logic         push, pop;

	assign in_ready = count_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != 2'd0;
	assign pop      = q_valid && q_ready;
	assign q_item   = buf_q[rd_ptr_q];

	// classify the byte by its position in the block
	always_comb begin
		item.data      = data_byte;
		item.last      = last_byte;
		item.restart   = !started_q;
		item.pos       = started_q ? pos_q : 6'd0;
		item.new_block = item.pos == 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			count_q   <= 2'd0;
			started_q <= 1'b0;
			pos_q     <= 6'd0;
		end else begin
			if (push) begin
				wr_ptr_q  <= !wr_ptr_q;
				started_q <= !last_byte;
				pos_q     <= last_byte ? 6'd0 : item.pos + 6'd1;
			end
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= item;
	end
endmodule

// ===== src/chacha_back.sv =====
`timescale 1ns / 1ps
module chacha_back
	import chacha_pkg::*;
#(
	parameter int ROUND_PAIRS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_ready,
	input  chacha_item_t q_item,
	input  logic [255:0] key,
	input  logic [95:0]  nonce,
	input  logic [31:0]  start_counter,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   result_byte,
	output logic         result_last
);
	localparam int QR_STEPS = ROUND_PAIRS * 8;
	localparam int SW = $clog2(QR_STEPS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;

	logic [1:0]    state_q;
	logic [SW-1:0] step_q;
	logic [31:0]   w_q [16];
	logic [31:0]   init_q [16];
	logic [31:0]   ks_q [16];
	logic [31:0]   count_q;
	logic          out_valid_q;
	logic          ks_ready_q;
	logic [7:0]    byte_q;
	logic          last_q;

	// quarter-round lane selection
	logic [3:0] ia, ib, ic, id;
	logic [1:0] col;
	logic       diag;
	logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
	logic [31:0] blk_ctr;
	logic        out_free, take_direct, start_blk;
	logic [31:0] word;

	assign col  = step_q[1:0];
	assign diag = step_q[2];
	always_comb begin
		ia = {2'b00, col};
		ib = {2'b01, diag ? col + 2'd1 : col};
		ic = {2'b10, diag ? col + 2'd2 : col};
		id = {2'b11, diag ? col + 2'd3 : col};
		a0 = w_q[ia] + w_q[ib];
		d0 = rotl(w_q[id] ^ a0, 16);
		c0 = w_q[ic] + d0;
		b0 = rotl(w_q[ib] ^ c0, 12);
		a1 = a0 + b0;
		d1 = rotl(d0 ^ a1, 8);
		c1 = c0 + d1;
		b1 = rotl(b0 ^ c1, 7);
		a2 = a1; b2 = b1; c2 = c1; d2 = d1;
	end

	// the first byte of a block starts a computation, then is taken once it is done
	assign blk_ctr   = q_item.restart ? start_counter : count_q;
	assign out_free  = !out_valid_q || out_ready;
	assign start_blk = state_q == ST_IDLE && q_valid && q_item.new_block && !ks_ready_q;
	assign take_direct = state_q == ST_IDLE && q_valid &&
		(!q_item.new_block || ks_ready_q) && out_free;
	assign q_ready  = take_direct;
	assign word     = ks_q[q_item.pos[5:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= 32'd0;
			out_valid_q <= 1'b0;
			ks_ready_q  <= 1'b0;
		end else begin
			if (take_direct) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start_blk) begin
						state_q <= ST_ROUND;
						step_q  <= '0;
						count_q <= blk_ctr;
					end else if (take_direct) begin
						ks_ready_q <= 1'b0;
						if (q_item.pos == 6'd63) count_q <= count_q + 32'd1;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(QR_STEPS - 1)) state_q <= ST_ADD;
				end
				ST_ADD: begin
					// the byte of a new block waits here until computed
					ks_ready_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// keystream computation and byte output datapath
	always_ff @(posedge clk) begin
		if (start_blk) begin
			init_q[0]  <= SIGMA_0; init_q[1] <= SIGMA_1;
			init_q[2]  <= SIGMA_2; init_q[3] <= SIGMA_3;
			for (int i = 0; i < 8; i++) init_q[4+i] <= key[32*i +: 32];
			init_q[12] <= blk_ctr;
			for (int i = 0; i < 3; i++) init_q[13+i] <= nonce[32*i +: 32];
			w_q[0] <= SIGMA_0; w_q[1] <= SIGMA_1;
			w_q[2] <= SIGMA_2; w_q[3] <= SIGMA_3;
			for (int i = 0; i < 8; i++) w_q[4+i] <= key[32*i +: 32];
			w_q[12] <= blk_ctr;
			for (int i = 0; i < 3; i++) w_q[13+i] <= nonce[32*i +: 32];
		end else if (state_q == ST_ROUND) begin
			w_q[ia] <= a2; w_q[ib] <= b2; w_q[ic] <= c2; w_q[id] <= d2;
		end else if (state_q == ST_ADD) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= w_q[i] + init_q[i];
		end
		if (take_direct) begin
			byte_q <= q_item.data ^ word[8*q_item.pos[1:0] +: 8];
			last_q <= q_item.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_byte = byte_q;
	assign result_last = last_q;
endmodule

// ===== src/chacha20_stream_cipher.sv =====
`timescale 1ns / 1ps
// ChaCha20 byte stream cipher.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..3
// key parts, 4 nonce low, 5 nonce high, 6 start counter; other indexes ignored.
// Write configuration only while the block is idle.
// Input channel: in_valid/in_ready with data_byte and last_byte.
// Output channel: out_valid/out_ready with result_byte and result_last.
// A two-entry queue parts the input side from the keystream engine.
// The first byte of each 64-byte block waits for a keystream block,
// computed one quarter-round at a time by the one shared quarter-round
// unit and then added to the initial state.
// Other bytes are taken back to back while the receiver accepts results;
// a byte's result passes through the queue and then the result register.
// A byte marked last restarts the next message at the start counter
// with a fresh block.
// Reset clears the configuration and control registers and empties queue
// and output; keystream and round registers are loaded before use.
// When the receiver stalls the result register holds, the queue fills
// and in_ready drops.
module chacha20_stream_cipher
	import chacha_pkg::*;
#(
	parameter int ROUND_PAIRS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  result_byte,
	output logic        result_last
);
	logic [255:0] key_q;
	logic [95:0]  nonce_q;
	logic [31:0]  start_q;
	logic         q_valid, q_ready;
	chacha_item_t q_item;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
			start_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_0:         key_q[63:0]    <= cfg_data;
				REG_KEY_1:         key_q[127:64]  <= cfg_data;
				REG_KEY_2:         key_q[191:128] <= cfg_data;
				REG_KEY_3:         key_q[255:192] <= cfg_data;
				REG_NONCE_LOW:     nonce_q[63:0]  <= cfg_data;
				REG_NONCE_HIGH:    nonce_q[95:64] <= cfg_data[31:0];
				REG_START_COUNTER: start_q        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	chacha_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .last_byte,
		.q_valid, .q_ready, .q_item
	);

	chacha_back #(.ROUND_PAIRS(ROUND_PAIRS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.key(key_q), .nonce(nonce_q), .start_counter(start_q),
		.out_valid, .out_ready, .result_byte, .result_last
	);
endmodule
